@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  `ASSERT_CLK(label, clk, rst, !(expr))
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ rtl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths and the transformed-vertex record passed front to back.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W     = 16;             // Q12.4 coordinate
  localparam int CNT_W       = 7;              // crossing counter, wraps
  localparam int DIFF_W      = COORD_W + 1;    // coordinate difference
  localparam int EDGE_PROD_W = 2 * DIFF_W;     // difference product
  localparam int CROSS_W     = EDGE_PROD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef struct packed {
    coord_t tx;
    coord_t ty;
    coord_t px;
    coord_t py;
    logic   first;
    logic   last;
  } vertex_t;

endpackage

@@ rtl/point_in_polygon_crossing_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Even-odd ray crossing test of a point against a streamed polygon.
// ----------------------------------------------------------------------------
// Usage: send one vertex per transfer on the in_valid/in_ready channel, the
// first vertex marked by first_vertex and the repeated closing vertex by
// last_vertex. Each vertex is rotated, rounded, translated and saturated in
// the front pipeline, then queued. The back end tests the edge from the
// previous vertex against the point and counts crossings. The closing vertex
// yields one result transfer (inside_res, crossings) on out_valid/out_ready.
// With the pipeline empty, the closing vertex passes the front product
// register, a queue entry, the back end's working registers and the output
// register before the result is valid. The back end takes a vertex only
// after the products and the sign test and count of the one before; the
// front takes one vertex per cycle until the QUEUE_DEPTH-entry queue fills.
// Reset clears the queue, the previous vertex and the count.
// A stalled result holds in the output register; the back end stops only at
// the next closing vertex, and the front keeps filling the queue meanwhile.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pip_pkg::coord_t point_x,
  input  pip_pkg::coord_t point_y,
  input  pip_pkg::coord_t offset_x,
  input  pip_pkg::coord_t offset_y,
  input  pip_pkg::coord_t rot_cos,
  input  pip_pkg::coord_t rot_sin,
  input  pip_pkg::coord_t vertex_x,
  input  pip_pkg::coord_t vertex_y,
  input  logic            first_vertex,
  input  logic            last_vertex,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            inside_res,
  output pip_pkg::count_t crossings
);
  import pip_pkg::*;

  vertex_t wr_data, rd_data;
  logic    q_push, q_full, q_pop, q_valid;

  pip_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .rot_cos      (rot_cos),
    .rot_sin      (rot_sin),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .first_vertex (first_vertex),
    .last_vertex  (last_vertex),
    .q_push       (q_push),
    .q_data       (wr_data),
    .q_full       (q_full)
  );

  pip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (rd_data),
    .not_empty (q_valid)
  );

  pip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (rd_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res),
    .crossings  (crossings)
  );

endmodule

@@ rtl/pip_front.sv @@
// ----------------------------------------------------------------------------
// pip_front
// Rotates a local vertex by cos/sin in Q1.14, rounds, translates and
// saturates. One product stage, then round and saturate into the queue.
// ----------------------------------------------------------------------------
module pip_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pip_pkg::coord_t  point_x,
  input  pip_pkg::coord_t  point_y,
  input  pip_pkg::coord_t  offset_x,
  input  pip_pkg::coord_t  offset_y,
  input  pip_pkg::coord_t  rot_cos,
  input  pip_pkg::coord_t  rot_sin,
  input  pip_pkg::coord_t  vertex_x,
  input  pip_pkg::coord_t  vertex_y,
  input  logic             first_vertex,
  input  logic             last_vertex,
  output logic             q_push,
  output pip_pkg::vertex_t q_data,
  input  logic             q_full
);
  import pip_pkg::*;

  localparam int PROD_W   = 2 * COORD_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int ROT_FRAC = 14;
  localparam int RND_W    = SUM_W - ROT_FRAC;
  localparam int TOT_W    = RND_W + 1;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (ROT_FRAC - 1);

  function automatic coord_t sat_coord(input logic signed [TOT_W-1:0] v);
    coord_t r;
    if (v[TOT_W-1:COORD_W-1] == '0 || v[TOT_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[TOT_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic                      s1_valid;
  logic signed [PROD_W-1:0]  p_cx, p_sy, p_sx, p_cy;
  coord_t                    s1_ox, s1_oy, s1_px, s1_py;
  logic                      s1_first, s1_last;

  logic signed [SUM_W-1:0]   sum_x, sum_y, bias_x, bias_y;
  logic signed [RND_W-1:0]   rnd_x, rnd_y;
  logic signed [TOT_W-1:0]   tot_x, tot_y;

  assign in_ready = !s1_valid || !q_full;
  assign q_push   = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      p_cx     <= PROD_W'(rot_cos) * PROD_W'(vertex_x);
      p_sy     <= PROD_W'(rot_sin) * PROD_W'(vertex_y);
      p_sx     <= PROD_W'(rot_sin) * PROD_W'(vertex_x);
      p_cy     <= PROD_W'(rot_cos) * PROD_W'(vertex_y);
      s1_ox    <= offset_x;
      s1_oy    <= offset_y;
      s1_px    <= point_x;
      s1_py    <= point_y;
      s1_first <= first_vertex;
      s1_last  <= last_vertex;
    end
  end

  // round half up: add half an LSB, keep the floor
  always_comb begin
    sum_x  = SUM_W'(p_cx) - SUM_W'(p_sy);
    sum_y  = SUM_W'(p_sx) + SUM_W'(p_cy);
    bias_x = sum_x + RND_HALF;
    bias_y = sum_y + RND_HALF;
    rnd_x  = bias_x[SUM_W-1:ROT_FRAC];
    rnd_y  = bias_y[SUM_W-1:ROT_FRAC];
    tot_x  = TOT_W'(rnd_x) + TOT_W'(s1_ox);
    tot_y  = TOT_W'(rnd_y) + TOT_W'(s1_oy);
    q_data.tx    = sat_coord(tot_x);
    q_data.ty    = sat_coord(tot_y);
    q_data.px    = s1_px;
    q_data.py    = s1_py;
    q_data.first = s1_first;
    q_data.last  = s1_last;
  end

endmodule

@@ rtl/pip_queue.sv @@
// ----------------------------------------------------------------------------
// pip_queue
// Small register FIFO of transformed vertices between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pip_pkg::vertex_t wr_data,
  output logic             full,
  input  logic             pop,
  output pip_pkg::vertex_t rd_data,
  output logic             not_empty
);
  import pip_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vertex_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign rd_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && !not_empty)
  `ASSERT_CLK(a_count_range, clk, rst, count <= CNT_W'(DEPTH))

endmodule

@@ rtl/pip_back.sv @@
// ----------------------------------------------------------------------------
// pip_back
// Edge-crossing test against the previous vertex and crossing count.
// Per vertex, in turn: difference products, then sign test and count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pip_pkg::vertex_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             inside_res,
  output pip_pkg::count_t  crossings
);
  import pip_pkg::*;

  typedef enum logic {S_IDLE, S_ACC} state_t;

  state_t                        state;
  coord_t                        prev_x, prev_y;
  logic                          have_prev;
  count_t                        count;

  coord_t                        w_tx, w_ty;
  logic                          w_last, w_test, w_dy_pos;
  count_t                        w_base;
  logic signed [EDGE_PROD_W-1:0] p1, p2;

  logic                          spans;
  logic signed [DIFF_W-1:0]      d_x1, d_y, d_py, d_x;
  logic signed [CROSS_W-1:0]     xprod;
  logic                          hit, finish, emit;
  count_t                        cnt_new;

  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    spans = (prev_y < q_data.py && q_data.ty >= q_data.py) ||
            (q_data.ty < q_data.py && prev_y >= q_data.py);
    d_x1  = DIFF_W'(prev_x) - DIFF_W'(q_data.px);
    d_y   = DIFF_W'(q_data.ty) - DIFF_W'(prev_y);
    d_py  = DIFF_W'(q_data.py) - DIFF_W'(prev_y);
    d_x   = DIFF_W'(q_data.tx) - DIFF_W'(prev_x);
  end

  // rising edge counts when xprod <= 0, falling edge when xprod >= 0
  always_comb begin
    xprod   = CROSS_W'(p1) + CROSS_W'(p2);
    hit     = w_test && (w_dy_pos ? (xprod[CROSS_W-1] || xprod == '0)
                                  : !xprod[CROSS_W-1]);
    cnt_new = w_base + CNT_W'(hit);
    finish  = !w_last || !out_valid || out_ready;
    emit    = (state == S_ACC) && finish && w_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      count     <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (finish) begin
            state     <= S_IDLE;
            prev_x    <= w_tx;
            prev_y    <= w_ty;
            have_prev <= !w_last;
            count     <= w_last ? '0 : cnt_new;
            if (w_last) begin
              inside_res <= cnt_new[0];
              crossings  <= cnt_new;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (q_pop) begin
      w_tx     <= q_data.tx;
      w_ty     <= q_data.ty;
      w_last   <= q_data.last;
      w_base   <= q_data.first ? '0 : count;
      w_test   <= have_prev && !q_data.first && spans;
      w_dy_pos <= q_data.ty > prev_y;
      p1       <= EDGE_PROD_W'(d_x1) * EDGE_PROD_W'(d_y);
      p2       <= EDGE_PROD_W'(d_py) * EDGE_PROD_W'(d_x);
    end
  end

  `ASSERT_CLK(a_out_from_last, clk, rst, $rose(out_valid) |-> $past(state == S_ACC && w_last))
  `ASSERT_CLK(a_parity, clk, rst, out_valid |-> inside_res == crossings[0])
  `ASSERT_CLK(a_pop_acc, clk, rst, q_pop |=> state == S_ACC && !q_pop)

endmodule
